### sv/gcdl_pkg.sv
package gcdl_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int MULT_WIDTH        = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TWOS,
    S_REDUCE,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

endpackage

### sv/gcdl_sub.sv
module gcdl_sub #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  logic [WIDTH:0] full;

  assign full   = {1'b0, x} - {1'b0, y};
  assign diff   = full[WIDTH-1:0];
  assign borrow = full[WIDTH];

endmodule

### sv/gcd_lcm_unit.sv
// result strobe in the cycle after the accepting edge when an operand is zero;
// otherwise the binary gcd loop runs first, then the radix-2 divide of a by the gcd,
// then the multiply, and finally the result strobe.
// gcd reduce and divide share one (OPERAND_WIDTH+1)-bit subtractor; one item at a time,
// start is taken again in the cycle after the result strobe (busy low).
// reset (synchronous, rst_n low) returns to idle with no result pending; no stall.
module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = gcdl_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [gcdl_pkg::FIELD_WIDTH-1:0] in_first_operand,
  input  logic [gcdl_pkg::FIELD_WIDTH-1:0] in_second_operand,
  output logic                             out_valid,
  output logic [gcdl_pkg::FIELD_WIDTH-1:0] out_divisor_out,
  output logic [gcdl_pkg::MULT_WIDTH-1:0]  out_multiple_out,
  output logic                             out_both_zero
);

  import gcdl_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(W);

  state_t state_r, state_nxt;

  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [W-1:0]   u_r, u_nxt;
  logic [W-1:0]   v_r, v_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [KW-1:0]  cnt_r, cnt_nxt;
  logic [2*W-1:0] prod_r, prod_nxt;
  logic           zero_r, zero_nxt;

  logic [W:0]     sub_x;
  logic [W:0]     sub_y;
  logic [W:0]     sub_diff;
  logic           sub_borrow;

  logic [W-1:0]   in_a;
  logic [W-1:0]   in_b;

  assign in_a = in_first_operand[W-1:0];
  assign in_b = in_second_operand[W-1:0];

  // shared subtractor: gcd reduce or divide trial
  assign sub_x = (state_r == S_DIV) ? {v_r, a_r[W-1]} : {1'b0, v_r};
  assign sub_y = {1'b0, u_r};

  gcdl_sub #(
    .WIDTH (W + 1)
  ) u_sub (
    .x      (sub_x),
    .y      (sub_y),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    zero_nxt  = zero_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt    = in_a;
          b_nxt    = in_b;
          u_nxt    = in_a;
          v_nxt    = in_b;
          k_nxt    = '0;
          zero_nxt = (in_a == '0) && (in_b == '0);
          if ((in_a == '0) || (in_b == '0)) begin
            u_nxt     = in_a | in_b;
            prod_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TWOS;
          end
        end
      end
      S_TWOS: begin
        // strip common factors of two
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (v_r == '0) begin
          u_nxt     = u_r << k_r;
          cnt_nxt   = KW'(W - 1);
          state_nxt = S_DIV;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (sub_borrow) begin
          u_nxt = v_r;
          v_nxt = u_r;
        end else begin
          v_nxt = sub_diff[W-1:0];
        end
      end
      S_DIV: begin
        // restoring divide of a by gcd, quotient shifts into a
        if (!sub_borrow) begin
          v_nxt = sub_diff[W-1:0];
          a_nxt = {a_r[W-2:0], 1'b1};
        end else begin
          v_nxt = sub_x[W-1:0];
          a_nxt = {a_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = {{W{1'b0}}, a_r} * {{W{1'b0}}, b_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_divisor_out  = FIELD_WIDTH'(u_r);
  assign out_multiple_out = MULT_WIDTH'(prod_r);
  assign out_both_zero    = zero_r;

endmodule

### sv/gcdl_check.sv
module gcdl_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [gcdl_pkg::FIELD_WIDTH-1:0] out_divisor_out,
  input logic [gcdl_pkg::MULT_WIDTH-1:0]  out_multiple_out,
  input logic                             out_both_zero
);

  import gcdl_pkg::*;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe not a single cycle ending the item");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside an item");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_both_zero |-> (out_divisor_out == '0) && (out_multiple_out == '0))
    else $error("both-zero result carries nonzero values");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor_out == '0) |-> out_both_zero)
    else $error("zero divisor without both-zero flag");

endmodule

bind gcd_lcm_unit gcdl_check u_gcdl_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_divisor_out  (out_divisor_out),
  .out_multiple_out (out_multiple_out),
  .out_both_zero    (out_both_zero)
);

### dv/gcd_lcm_unit_test.sv
`timescale 1ns / 100ps

module gcd_lcm_unit_test;

  localparam int FW = gcdl_pkg::FIELD_WIDTH;
  localparam int MW = gcdl_pkg::MULT_WIDTH;
  localparam int OP_W = gcdl_pkg::OPERAND_WIDTH_DEF;
  localparam logic [63:0] OPERAND_MASK = (64'd1 << OP_W) - 64'd1;
  localparam int ITEMS_PER_PHASE = 234;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 4000;
  localparam int NUM_ROWS = 19;

  typedef struct packed {
    logic [FW-1:0] divisor;
    logic [MW-1:0] multiple;
    logic          both_zero;
  } gcd_lcm_t;

  typedef struct packed {
    logic [FW-1:0] op_a;
    logic [FW-1:0] op_b;
    logic          typed;
    gcd_lcm_t      result;
  } operand_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [FW-1:0] in_first_operand = '0;
  logic [FW-1:0] in_second_operand = '0;
  logic          out_valid;
  logic [FW-1:0] out_divisor_out;
  logic [MW-1:0] out_multiple_out;
  logic          out_both_zero;

  gcd_lcm_t expected_gcd_lcm_q[$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       sender_idle_pct = 0;

  operand_row_t corner_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 64'h0, 1'b1}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'h0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 64'h0, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 64'h0, 1'b0}},
    '{32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h8000_0000, 64'h0, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'h1, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b0}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 64'hFFFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'hFFFF_FFFF, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 64'h8000_0000, 1'b0}},
    '{32'h0000_000C, 32'h0000_0012, 1'b1, '{32'h0000_0006, 64'h24, 1'b0}},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0001, 64'h8000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'hFFFF_FFFB, 32'hFFFF_FFF1, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{32'h8000_0000, 32'h0000_0003, 1'b0, '0},
    '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
    '{32'h7FFF_FFFF, 32'h8000_0001, 1'b0, '0}
  };

  gcd_lcm_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_first_operand  (in_first_operand),
    .in_second_operand (in_second_operand),
    .out_valid         (out_valid),
    .out_divisor_out   (out_divisor_out),
    .out_multiple_out  (out_multiple_out),
    .out_both_zero     (out_both_zero)
  );

  always #10ns clk = ~clk;

  function automatic gcd_lcm_t gcd_lcm_of(input logic [FW-1:0] op_a, input logic [FW-1:0] op_b);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    gcd_lcm_t    res;
    a = {32'h0, op_a} & OPERAND_MASK;
    b = {32'h0, op_b} & OPERAND_MASK;
    res = '0;
    if (a == 64'h0 && b == 64'h0) begin
      res.both_zero = 1'b1;
    end else if (a == 64'h0 || b == 64'h0) begin
      res.divisor = FW'(a | b);
    end else begin
      x = a;
      y = b;
      while (y != 64'h0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor = FW'(x);
      res.multiple = (a / x) * b;
    end
    return res;
  endfunction

  function automatic void pick_operands(output logic [FW-1:0] a, output logic [FW-1:0] b);
    int unsigned kind;
    int unsigned kw;
    logic [FW-1:0] k;
    kind = $urandom_range(99);
    a = $urandom;
    b = $urandom;
    if (kind < 30) begin
      // full-range operands
    end else if (kind < 55) begin
      // shared factor
      kw = $urandom_range(31, 1);
      k = $urandom >> (32 - kw);
      a = k * (a >> kw);
      b = k * (b >> kw);
    end else if (kind < 70) begin
      a = $urandom_range(255);
      b = $urandom_range(255);
    end else if (kind < 80) begin
      if ($urandom_range(1) == 0) begin
        a = '0;
      end else begin
        b = '0;
      end
    end else if (kind < 85) begin
      a = '0;
      b = '0;
    end else if (kind < 93) begin
      a = ($urandom_range(255) | 1) << $urandom_range(31);
      b = ($urandom_range(255) | 1) << $urandom_range(31);
    end else begin
      b = a;
    end
  endfunction

  // holds start until the beat is taken, leaves start high
  task automatic issue_operands(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                input gcd_lcm_t want);
    in_first_operand <= a;
    in_second_operand <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_gcd_lcm_q.push_back(want);
  endtask

  task automatic idle_sender();
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_gcd_lcm_q.size() != 0);
  endtask

  always @(posedge clk) begin
    gcd_lcm_t want;
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && out_valid) begin
      if (expected_gcd_lcm_q.size() == 0) begin
        $error("result beat with nothing expected: divisor %0h multiple %0h both_zero %0b",
               out_divisor_out, out_multiple_out, out_both_zero);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_gcd_lcm_q.pop_front();
        if (out_divisor_out !== want.divisor) begin
          $error("divisor_out expected %0h actual %0h", want.divisor, out_divisor_out);
          mismatch_count = mismatch_count + 1;
        end
        if (out_multiple_out !== want.multiple) begin
          $error("multiple_out expected %0h actual %0h", want.multiple, out_multiple_out);
          mismatch_count = mismatch_count + 1;
        end
        if (out_both_zero !== want.both_zero) begin
          $error("both_zero expected %0b actual %0b", want.both_zero, out_both_zero);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("gcd_lcm_unit_test failed");
      $finish;
    end
  end

  initial begin
    logic [FW-1:0] a;
    logic [FW-1:0] b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 11;
    foreach (corner_rows[i]) begin
      issue_operands(corner_rows[i].op_a, corner_rows[i].op_b,
                     corner_rows[i].typed ? corner_rows[i].result
                                          : gcd_lcm_of(corner_rows[i].op_a, corner_rows[i].op_b));
      idle_sender();
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 57 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_operands(a, b);
        issue_operands(a, b, gcd_lcm_of(a, b));
        if ($urandom_range(49) == 0) begin
          drain_results();
        end else begin
          idle_sender();
        end
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_gcd_lcm_q.size() == 0) begin
      $display("gcd_lcm_unit_test passed");
    end else begin
      $display("gcd_lcm_unit_test failed");
    end
    $finish;
  end

endmodule
